/* sv/rcp_pkg.sv */
`timescale 1ns / 1ps
// types, constants and helpers shared by the pulse-to-control pipeline
// no dependencies
package rcp_pkg;

    localparam int PULSE_W    = 12;
    localparam int BAND_W     = 8;
    localparam int SCALE_W    = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int VAL_W      = 14;
    localparam int MAG_W      = 13;
    localparam int QUO_W      = 16;
    localparam int PROD_W     = SCALE_W + MAG_W;
    localparam int REM_W      = MAG_W + QUO_W;
    localparam int CTRL_W     = 16;

    localparam logic [PULSE_W-1:0] RST_PULSE_MIN    = 12'd1100;
    localparam logic [PULSE_W-1:0] RST_PULSE_TRIM   = 12'd1500;
    localparam logic [PULSE_W-1:0] RST_PULSE_MAX    = 12'd1900;
    localparam logic               RST_REVERSE      = 1'b0;
    localparam logic [BAND_W-1:0]  RST_DEAD_BAND    = 8'd0;
    localparam logic               RST_ANGLE_MODE   = 1'b1;
    localparam logic [SCALE_W-1:0] RST_OUTPUT_SCALE = 15'd4500;

    localparam logic signed [CTRL_W-1:0] CTRL_MAX = 16'sh7FFF;
    localparam logic signed [CTRL_W-1:0] CTRL_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_MIN    = 3'd0,
        REG_PULSE_TRIM   = 3'd1,
        REG_PULSE_MAX    = 3'd2,
        REG_REVERSE      = 3'd3,
        REG_DEAD_BAND    = 3'd4,
        REG_ANGLE_MODE   = 3'd5,
        REG_OUTPUT_SCALE = 3'd6
    } cfg_index_t;

    typedef logic signed [VAL_W-1:0] sval_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic               apply_dead_zone;
    } in_item_t;

    typedef struct packed {
        logic signed [CTRL_W-1:0] control_value;
        logic                     in_trim_zone;
    } out_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_min;
        logic [PULSE_W-1:0] pulse_trim;
        logic [PULSE_W-1:0] pulse_max;
        logic               reverse_input;
        logic [BAND_W-1:0]  dead_band;
        logic               angle_mode;
        logic [SCALE_W-1:0] output_scale;
    } cfg_t;

    // operands ready for the multiply
    typedef struct packed {
        logic             zero;
        logic             neg;
        logic             trim;
        logic [MAG_W-1:0] nmag;
        logic [MAG_W-1:0] dmag;
    } mul_item_t;

    // one item in flight through the divider
    typedef struct packed {
        logic             zero;
        logic             neg;
        logic             trim;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] dmag;
        logic [QUO_W-1:0] quo;
    } div_item_t;

    function automatic sval_t ext_pulse(input logic [PULSE_W-1:0] v);
        ext_pulse = sval_t'({{(VAL_W-PULSE_W){1'b0}}, v});
    endfunction

    function automatic sval_t ext_band(input logic [BAND_W-1:0] v);
        ext_band = sval_t'({{(VAL_W-BAND_W){1'b0}}, v});
    endfunction

    function automatic logic [MAG_W-1:0] abs_mag(input sval_t v);
        sval_t t;
        t = (v < 0) ? -v : v;
        abs_mag = t[MAG_W-1:0];
    endfunction

endpackage

/* sv/rcp_front.sv */
`timescale 1ns / 1ps
// front end: clamp, mirror, dead zone and trim window, three register stages
// depends on rcp_pkg
module rcp_front
    import rcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      up_valid,
    output logic      up_ready,
    input  in_item_t  up_item,
    output logic      dn_valid,
    input  logic      dn_ready,
    output mul_item_t dn_item
);

    typedef struct packed {
        sval_t p;
        sval_t rc;
        sval_t hi;
        sval_t lo;
        sval_t bottom;
        logic  trim;
    } sta_t;

    typedef struct packed {
        sval_t rr;
        sval_t span;
        sval_t bottom;
        sval_t anum;
        sval_t aden;
        logic  azero;
        logic  trim;
    } stb_t;

    sta_t      a_reg, a_next;
    stb_t      b_reg, b_next;
    mul_item_t c_reg, c_next;
    logic      va_reg, vb_reg, vc_reg;
    logic      rdy_a, rdy_b, rdy_c;

    sval_t mn, tr, mx;

    assign mn = ext_pulse(cfg.pulse_min);
    assign tr = ext_pulse(cfg.pulse_trim);
    assign mx = ext_pulse(cfg.pulse_max);

    assign rdy_c    = !vc_reg || dn_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign up_ready = rdy_a;
    assign dn_valid = vc_reg;
    assign dn_item  = c_reg;

    // stage a: clamp, window bounds
    always_comb
    begin
        sval_t p;
        sval_t dz;
        sval_t db;
        p  = ext_pulse(up_item.pulse_width);
        db = ext_band(cfg.dead_band);
        dz = up_item.apply_dead_zone ? db : '0;
        a_next.p = p;
        if (p < mn)
        begin
            a_next.rc = mn;
        end
        else if (p > mx)
        begin
            a_next.rc = mx;
        end
        else
        begin
            a_next.rc = p;
        end
        a_next.hi     = tr + dz;
        a_next.lo     = tr - dz;
        a_next.bottom = mn + dz;
        a_next.trim   = (p >= tr - db) && (p <= tr + db);
    end

    // stage b: mirror, spans, angle side selection
    always_comb
    begin
        logic up;
        logic dn;
        up = (a_reg.p > a_reg.hi) && (mx != a_reg.hi);
        dn = (a_reg.p < a_reg.lo) && (a_reg.lo != mn);
        b_next.rr     = cfg.reverse_input ? (mx + mn - a_reg.rc) : a_reg.rc;
        b_next.span   = mx - a_reg.bottom;
        b_next.bottom = a_reg.bottom;
        b_next.anum   = up ? (a_reg.p - a_reg.hi) : (a_reg.p - a_reg.lo);
        b_next.aden   = up ? (mx - a_reg.hi) : (a_reg.lo - mn);
        b_next.azero  = !(up || dn);
        b_next.trim   = a_reg.trim;
    end

    // stage c: magnitudes and sign for the divider
    always_comb
    begin
        sval_t rdiff;
        rdiff = b_reg.rr - b_reg.bottom;
        c_next.trim = b_reg.trim;
        if (cfg.angle_mode)
        begin
            c_next.zero = b_reg.azero;
            c_next.neg  = b_reg.anum[VAL_W-1] ^ b_reg.aden[VAL_W-1] ^ cfg.reverse_input;
            c_next.nmag = abs_mag(b_reg.anum);
            c_next.dmag = abs_mag(b_reg.aden);
        end
        else
        begin
            c_next.zero = (rdiff <= 0) || (b_reg.span <= 0);
            c_next.neg  = 1'b0;
            c_next.nmag = rdiff[MAG_W-1:0];
            c_next.dmag = b_reg.span[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= up_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
            if (rdy_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            a_reg <= a_next;
        end
        if (rdy_b)
        begin
            b_reg <= b_next;
        end
        if (rdy_c)
        begin
            c_reg <= c_next;
        end
    end

endmodule

/* sv/rcp_mul.sv */
`timescale 1ns / 1ps
// scale multiply and quotient overflow check, two register stages
// depends on rcp_pkg
module rcp_mul
    import rcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      up_valid,
    output logic      up_ready,
    input  mul_item_t up_item,
    output logic      dn_valid,
    input  logic      dn_ready,
    output div_item_t dn_item
);

    typedef struct packed {
        logic              zero;
        logic              neg;
        logic              trim;
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  dmag;
    } prod_t;

    prod_t     p_reg, p_next;
    div_item_t d_reg, d_next;
    logic      vp_reg, vd_reg;
    logic      rdy_p, rdy_d;

    assign rdy_d    = !vd_reg || dn_ready;
    assign rdy_p    = !vp_reg || rdy_d;
    assign up_ready = rdy_p;
    assign dn_valid = vd_reg;
    assign dn_item  = d_reg;

    always_comb
    begin
        p_next.zero = up_item.zero;
        p_next.neg  = up_item.neg;
        p_next.trim = up_item.trim;
        p_next.dmag = up_item.dmag;
        p_next.prod = PROD_W'(cfg.output_scale) * PROD_W'(up_item.nmag);
    end

    // quotient needs more than QUO_W bits when product >= divisor << QUO_W
    always_comb
    begin
        d_next.zero = p_reg.zero;
        d_next.neg  = p_reg.neg;
        d_next.trim = p_reg.trim;
        d_next.dmag = p_reg.dmag;
        d_next.rem  = REM_W'(p_reg.prod);
        d_next.ovf  = REM_W'(p_reg.prod) >= (REM_W'(p_reg.dmag) << QUO_W);
        d_next.quo  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (rdy_p)
            begin
                vp_reg <= up_valid;
            end
            if (rdy_d)
            begin
                vd_reg <= vp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_p)
        begin
            p_reg <= p_next;
        end
        if (rdy_d)
        begin
            d_reg <= d_next;
        end
    end

endmodule

/* sv/rcp_div.sv */
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per register stage
// depends on rcp_pkg
module rcp_div
    import rcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  div_item_t up_item,
    output logic      dn_valid,
    input  logic      dn_ready,
    output div_item_t dn_item
);

    localparam int LAST = QUO_W - 1;

    div_item_t st_reg [QUO_W];
    div_item_t st_in  [QUO_W];
    logic      v_reg  [QUO_W];
    logic      v_in   [QUO_W];
    logic      rdy    [QUO_W+1];

    assign rdy[QUO_W] = dn_ready;
    assign up_ready   = rdy[0];
    assign dn_valid   = v_reg[LAST];
    assign dn_item    = st_reg[LAST];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int B = QUO_W - 1 - k;

        logic [REM_W-1:0] shifted;
        div_item_t        nxt;

        if (k == 0)
        begin : g_first
            assign st_in[k] = up_item;
            assign v_in[k]  = up_valid;
        end
        else
        begin : g_rest
            assign st_in[k] = st_reg[k-1];
            assign v_in[k]  = v_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb
        begin
            nxt     = st_in[k];
            shifted = REM_W'(st_in[k].dmag) << B;
            if (st_in[k].rem >= shifted)
            begin
                nxt.rem    = st_in[k].rem - shifted;
                nxt.quo[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                st_reg[k] <= nxt;
            end
        end
    end

    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST] && !dn_ready |=> v_reg[LAST])
        else $error("divider output lost while stalled");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST] && !st_reg[LAST].zero && !st_reg[LAST].ovf
        |-> st_reg[LAST].rem < REM_W'(st_reg[LAST].dmag))
        else $error("final remainder not below divisor");

    a_entry_fits: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && rdy[0] && !up_item.zero && !up_item.ovf
        |-> up_item.rem < (REM_W'(up_item.dmag) << QUO_W))
        else $error("dividend entering divider overflows quotient width");

endmodule

/* sv/rc_pulse_to_control_unit.sv */
`timescale 1ns / 1ps
// Pulse width to control value converter, top level.
// Input channel: in_valid / in_stall / in_data (pulse_width, apply_dead_zone).
// Output channel: out_valid / out_stall / out_data (control_value, in_trim_zone).
// A transfer happens on a rising edge with valid high and stall low.
// Configuration: cfg_write with cfg_index and cfg_data writes one register;
// indexes beyond the list are ignored. Write only while no item is in flight.
// An item passes from input transfer to output transfer through three front end
// stages, the scale multiply, the overflow check, sixteen divider stages (one
// quotient bit each) and the output register.
// Throughput is one item per cycle while out_stall is low; the divider stages set the depth.
// Every stage holds its own valid bit, so when the receiver stalls the stages
// behind the first empty slot keep moving and in_stall only rises once the
// whole pipeline is full.
// Reset clears all valid bits and loads the register defaults
// (min 1100, trim 1500, max 1900, angle mode, scale 4500).
// depends on rcp_pkg, rcp_front, rcp_mul, rcp_div
module rc_pulse_to_control_unit
    import rcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    cfg_t      cfg_reg;
    logic      front_ready, front_valid;
    mul_item_t front_item;
    logic      mul_ready, mul_valid;
    div_item_t mul_item;
    logic      div_ready, div_valid;
    div_item_t div_item;
    logic      out_ready;
    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_min     <= RST_PULSE_MIN;
            cfg_reg.pulse_trim    <= RST_PULSE_TRIM;
            cfg_reg.pulse_max     <= RST_PULSE_MAX;
            cfg_reg.reverse_input <= RST_REVERSE;
            cfg_reg.dead_band     <= RST_DEAD_BAND;
            cfg_reg.angle_mode    <= RST_ANGLE_MODE;
            cfg_reg.output_scale  <= RST_OUTPUT_SCALE;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_PULSE_MIN:    cfg_reg.pulse_min     <= cfg_data[PULSE_W-1:0];
                REG_PULSE_TRIM:   cfg_reg.pulse_trim    <= cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX:    cfg_reg.pulse_max     <= cfg_data[PULSE_W-1:0];
                REG_REVERSE:      cfg_reg.reverse_input <= cfg_data[0];
                REG_DEAD_BAND:    cfg_reg.dead_band     <= cfg_data[BAND_W-1:0];
                REG_ANGLE_MODE:   cfg_reg.angle_mode    <= cfg_data[0];
                REG_OUTPUT_SCALE: cfg_reg.output_scale  <= cfg_data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    rcp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (in_valid),
        .up_ready (front_ready),
        .up_item  (in_data),
        .dn_valid (front_valid),
        .dn_ready (mul_ready),
        .dn_item  (front_item)
    );

    rcp_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (front_valid),
        .up_ready (mul_ready),
        .up_item  (front_item),
        .dn_valid (mul_valid),
        .dn_ready (div_ready),
        .dn_item  (mul_item)
    );

    rcp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mul_valid),
        .up_ready (div_ready),
        .up_item  (mul_item),
        .dn_valid (div_valid),
        .dn_ready (out_ready),
        .dn_item  (div_item)
    );

    assign in_stall  = !front_ready;
    assign out_ready = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // sign and saturation
    always_comb
    begin
        logic [QUO_W:0] negq;
        negq = {(QUO_W+1){1'b0}} - {1'b0, div_item.quo};
        out_item_next.in_trim_zone = div_item.trim;
        if (div_item.zero)
        begin
            out_item_next.control_value = '0;
        end
        else if (div_item.ovf)
        begin
            out_item_next.control_value = div_item.neg ? CTRL_MIN : CTRL_MAX;
        end
        else if (div_item.neg)
        begin
            if (div_item.quo > QUO_W'(unsigned'(CTRL_MIN)))
            begin
                out_item_next.control_value = CTRL_MIN;
            end
            else
            begin
                out_item_next.control_value = negq[CTRL_W-1:0];
            end
        end
        else
        begin
            if (div_item.quo > QUO_W'(unsigned'(CTRL_MAX)))
            begin
                out_item_next.control_value = CTRL_MAX;
            end
            else
            begin
                out_item_next.control_value = div_item.quo[CTRL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for rc_pulse_to_control_unit: a directed table, then randomised phases
// results are typed or predicted from a register shadow, compared in order of transfer
// depends on rcp_pkg and the rc_pulse_to_control_unit rtl
module tb_top;
    import rcp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int PULSE_TOP      = (1 << PULSE_W) - 1;
    localparam int DATA_TOP       = (1 << CFG_DATA_W) - 1;
    localparam int PHASES         = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PRESSURE_PHASE = 4;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        in_item_t              item;
        logic                  typed;
        out_item_t             result;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;

    cfg_t      regs_shadow;
    out_item_t pending_controls[$];
    stim_row_t directed_rows[$];
    int        errors;
    int        items_sent;
    int        results_seen;
    int        settings_used;
    int        idle_max;
    bit        hold_off_req;
    int        quiet_cycles;

    rc_pulse_to_control_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [CTRL_W-1:0] clip_ctrl(input longint v);
        if (v > longint'(CTRL_MAX))
            return CTRL_MAX;
        if (v < longint'(CTRL_MIN))
            return CTRL_MIN;
        return v[CTRL_W-1:0];
    endfunction

    function automatic out_item_t predict_control(input in_item_t it, input cfg_t c);
        longint    p, mn, tr, mx, sc, band, dz, dir;
        longint    hi_edge, lo_edge, r, bottom, span, val;
        out_item_t res;
        p    = longint'(it.pulse_width);
        mn   = longint'(c.pulse_min);
        tr   = longint'(c.pulse_trim);
        mx   = longint'(c.pulse_max);
        sc   = longint'(c.output_scale);
        band = longint'(c.dead_band);
        dz   = it.apply_dead_zone ? band : 0;
        dir  = c.reverse_input ? -1 : 1;
        val  = 0;
        if (c.angle_mode)
        begin
            hi_edge = tr + dz;
            lo_edge = tr - dz;
            if (p > hi_edge && mx != hi_edge)
                val = dir * sc * (p - hi_edge) / (mx - hi_edge);
            else if (p < lo_edge && lo_edge != mn)
                val = dir * sc * (p - lo_edge) / (lo_edge - mn);
        end
        else
        begin
            r      = p;
            bottom = mn + dz;
            if (r < mn)
                r = mn;
            else if (r > mx)
                r = mx;
            if (c.reverse_input)
                r = mx - (r - mn);
            span = mx - bottom;
            if (r > bottom && span > 0)
                val = sc * (r - bottom) / span;
        end
        res.control_value = clip_ctrl(val);
        res.in_trim_zone  = (p >= tr - band) && (p <= tr + band);
        return res;
    endfunction

    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PULSE_MIN:    regs_shadow.pulse_min     = data[PULSE_W-1:0];
            REG_PULSE_TRIM:   regs_shadow.pulse_trim    = data[PULSE_W-1:0];
            REG_PULSE_MAX:    regs_shadow.pulse_max     = data[PULSE_W-1:0];
            REG_REVERSE:      regs_shadow.reverse_input = data[0];
            REG_DEAD_BAND:    regs_shadow.dead_band     = data[BAND_W-1:0];
            REG_ANGLE_MODE:   regs_shadow.angle_mode    = data[0];
            REG_OUTPUT_SCALE: regs_shadow.output_scale  = data[SCALE_W-1:0];
            default:          ;
        endcase
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.is_write = 1'b1;
        row.idx      = idx;
        row.data     = data;
        row.item     = '0;
        row.typed    = 1'b0;
        row.result   = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(input int pw, input bit adz, input bit typed = 1'b0,
                                     input int cv = 0, input bit tz = 1'b0);
        stim_row_t row;
        row.is_write             = 1'b0;
        row.idx                  = '0;
        row.data                 = '0;
        row.item.pulse_width     = pw[PULSE_W-1:0];
        row.item.apply_dead_zone = adz;
        row.typed                = typed;
        row.result.control_value = cv[CTRL_W-1:0];
        row.result.in_trim_zone  = tz;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_result(input out_item_t got);
        out_item_t want;
        results_seen++;
        if (pending_controls.size() == 0)
        begin
            $error("result with no transfer waiting: control_value %0d", got.control_value);
            errors++;
            return;
        end
        want = pending_controls.pop_front();
        if (got.control_value !== want.control_value)
        begin
            $error("control_value: expected %0d, actual %0d",
                   want.control_value, got.control_value);
            errors++;
        end
        if (got.in_trim_zone !== want.in_trim_zone)
        begin
            $error("in_trim_zone: expected %0b, actual %0b",
                   want.in_trim_zone, got.in_trim_zone);
            errors++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        shadow_write(idx, data);
    endtask

    task automatic end_writes;
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_until_idle;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_controls.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic send_item(input in_item_t it, input logic typed, input out_item_t typed_result);
        int gap;
        gap = $urandom_range(0, idle_max);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_controls.push_back(typed ? typed_result : predict_control(it, regs_shadow));
        items_sent++;
    endtask

    // receiver: random hold-off before each transfer, one long one on request
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = $urandom_range(0, idle_max);
            if (hold_off_req)
            begin
                hold = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            if (hold > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            check_result(out_data);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int                    phase, k, lo, hi, t;
        bit                    writing;
        in_item_t              it;
        logic [CFG_DATA_W-1:0] v_min, v_trim, v_max, v_rev, v_band, v_angle, v_scale;

        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        settings_used = 1;
        idle_max      = 9;
        hold_off_req  = 1'b0;
        regs_shadow   = '{pulse_min: 12'd1100, pulse_trim: 12'd1500, pulse_max: 12'd1900,
                          reverse_input: 1'b0, dead_band: 8'd0, angle_mode: 1'b1,
                          output_scale: 15'd4500};

        // reset settings, angle mode
        add_item(1500, 1'b0, 1'b1, 0, 1'b1);
        add_item(1900, 1'b0, 1'b1, 4500, 1'b0);
        add_item(1100, 1'b0, 1'b1, -4500, 1'b0);
        add_item(1700, 1'b1, 1'b1, 2250, 1'b0);
        add_item(0, 1'b0);
        add_item(PULSE_TOP, 1'b1);
        // dead zone and reversal; flag ignores the per-item choice
        add_write(REG_DEAD_BAND, 200);
        add_write(REG_REVERSE, 1);
        add_item(1500, 1'b0, 1'b1, 0, 1'b1);
        add_item(1700, 1'b1, 1'b1, 0, 1'b1);
        add_item(1701, 1'b0);
        add_item(1299, 1'b1);
        // upper span of zero
        add_write(REG_PULSE_MAX, 1700);
        add_item(2000, 1'b1, 1'b1, 0, 1'b0);
        add_item(2000, 1'b0);
        // saturation both ways
        add_write(REG_OUTPUT_SCALE, 32767);
        add_write(REG_REVERSE, 0);
        add_item(PULSE_TOP, 1'b0, 1'b1, CTRL_MAX, 1'b0);
        add_item(0, 1'b0, 1'b1, CTRL_MIN, 1'b0);
        // negative lower span, then a write to an unused index
        add_write(REG_PULSE_MIN, 2200);
        add_item(1000, 1'b0);
        add_write(REG_UNUSED, CFG_DATA_W'(DATA_TOP));
        add_item(1000, 1'b1);
        // range mode
        add_write(REG_ANGLE_MODE, 0);
        add_write(REG_PULSE_MIN, 1000);
        add_write(REG_PULSE_MAX, 2000);
        add_write(REG_OUTPUT_SCALE, 1000);
        add_write(REG_DEAD_BAND, 100);
        add_item(0, 1'b1, 1'b1, 0, 1'b0);
        add_item(PULSE_TOP, 1'b1, 1'b1, 1000, 1'b0);
        add_item(1550, 1'b1);
        add_item(1550, 1'b0, 1'b1, 550, 1'b1);
        add_write(REG_REVERSE, 1);
        add_item(0, 1'b0, 1'b1, 1000, 1'b0);
        add_item(1234, 1'b1);
        // minimum above maximum
        add_write(REG_PULSE_MIN, 2100);
        add_item(1500, 1'b0, 1'b1, 0, 1'b1);
        // bottom point above maximum
        add_write(REG_PULSE_MIN, 1000);
        add_write(REG_PULSE_MAX, 1100);
        add_write(REG_DEAD_BAND, 200);
        add_item(1100, 1'b1, 1'b1, 0, 1'b0);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        writing = 1'b0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                if (!writing)
                begin
                    wait_until_idle();
                    writing = 1'b1;
                end
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                if (writing)
                begin
                    end_writes();
                    writing = 1'b0;
                end
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].result);
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_until_idle();
            idle_max = (phase % 3 == 2) ? 0 : 9;
            v_min   = CFG_DATA_W'($urandom_range(800, 1400));
            v_max   = CFG_DATA_W'($urandom_range(1600, 2200));
            v_trim  = CFG_DATA_W'($urandom_range(v_min, v_max));
            v_rev   = CFG_DATA_W'($urandom_range(0, 1));
            v_band  = CFG_DATA_W'($urandom_range(0, 200));
            v_angle = CFG_DATA_W'($urandom_range(0, 1));
            v_scale = CFG_DATA_W'($urandom_range(0, 32767));
            if ($urandom_range(0, 3) == 0)
            begin
                v_min  = CFG_DATA_W'($urandom_range(800, 2200));
                v_trim = CFG_DATA_W'($urandom_range(800, 2200));
                v_max  = CFG_DATA_W'($urandom_range(800, 2200));
            end
            case (phase)
                0:
                begin
                    v_min = 800; v_trim = 800; v_max = 2200; v_rev = 0;
                    v_band = 0; v_angle = 0; v_scale = 32767;
                end
                1:
                begin
                    v_min = 800; v_trim = 2200; v_max = 2200; v_rev = 1;
                    v_band = 200; v_angle = 1; v_scale = 32767;
                end
                2:
                begin
                    v_min = 2200; v_trim = 2200; v_max = 2200; v_rev = 0;
                    v_band = 200; v_angle = 1; v_scale = 0;
                end
                3:
                begin
                    // full-width data, the block keeps only the low bits
                    v_min   = CFG_DATA_W'($urandom_range(0, DATA_TOP));
                    v_trim  = CFG_DATA_W'($urandom_range(0, DATA_TOP));
                    v_max   = CFG_DATA_W'($urandom_range(0, DATA_TOP));
                    v_rev   = CFG_DATA_W'($urandom_range(0, DATA_TOP));
                    v_band  = CFG_DATA_W'($urandom_range(0, DATA_TOP));
                    v_angle = CFG_DATA_W'($urandom_range(0, DATA_TOP));
                    v_scale = CFG_DATA_W'($urandom_range(0, DATA_TOP));
                    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, DATA_TOP)));
                end
                default: ;
            endcase
            write_reg(REG_PULSE_MIN, v_min);
            write_reg(REG_PULSE_TRIM, v_trim);
            write_reg(REG_PULSE_MAX, v_max);
            write_reg(REG_REVERSE, v_rev);
            write_reg(REG_DEAD_BAND, v_band);
            write_reg(REG_ANGLE_MODE, v_angle);
            write_reg(REG_OUTPUT_SCALE, v_scale);
            end_writes();

            lo = int'(regs_shadow.pulse_min);
            hi = int'(regs_shadow.pulse_max);
            if (lo > hi)
            begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            lo = (lo > 300) ? lo - 300 : 0;
            hi = (hi + 300 < PULSE_TOP) ? hi + 300 : PULSE_TOP;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (phase == PRESSURE_PHASE && k == 40)
                    hold_off_req = 1'b1;
                if ($urandom_range(0, 4) != 0)
                    it.pulse_width = PULSE_W'($urandom_range(lo, hi));
                else
                    it.pulse_width = PULSE_W'($urandom_range(0, PULSE_TOP));
                it.apply_dead_zone = 1'($urandom_range(0, 1));
                send_item(it, 1'b0, '0);
            end
        end

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d transfers in, %0d results checked across %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("range and angle modes, reversal, dead zones, saturation, %0d mismatches",
                 errors);
        if (errors == 0 && pending_controls.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
